// ----- rtl/kca_pkg.sv -----
// shared types, key table and register codes for the key click autorepeat block
package kca_pkg;

  // number of keys the design uses, capped by the built-in table
  localparam int KEY_ENTRIES = 16;
  localparam int TABLE_SIZE  = 16;
  localparam int ENTRIES     = (KEY_ENTRIES > TABLE_SIZE) ? TABLE_SIZE : KEY_ENTRIES;
  localparam int IDX_W       = $clog2(TABLE_SIZE);

  // field widths
  localparam int WORD_W = 32;
  localparam int KEY_W  = 5;
  localparam int CFG_W  = 16;
  localparam int CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_DELAY     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_INTERVAL = 2'd1;

  // register reset values
  localparam logic [CFG_W-1:0] FIRST_DELAY_RESET     = 16'd500;
  localparam logic [CFG_W-1:0] REPEAT_INTERVAL_RESET = 16'd175;

  // key table: group select and bit mask per key position
  localparam logic KEY_GRP [TABLE_SIZE] = '{
    1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
    1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1
  };
  localparam logic [WORD_W-1:0] KEY_MASK [TABLE_SIZE] = '{
    32'h0000_0003, 32'h0000_0002, 32'h0000_0001, 32'h0000_0008,
    32'h0000_0010, 32'h0000_0200, 32'h0000_0400, 32'h0000_0800,
    32'h0000_1000, 32'h0000_2000, 32'h0000_4000, 32'h0000_8000,
    32'h0001_0000, 32'h0002_0000, 32'h0004_0000, 32'h0008_0000
  };

  // one scan item
  typedef struct packed {
    logic [WORD_W-1:0] scan_group0;
    logic [WORD_W-1:0] scan_group1;
    logic [WORD_W-1:0] tick_now;
    logic              clear_hold;
  } scan_item_t;

  // one result item
  typedef struct packed {
    logic [KEY_W-1:0] key_index;
    logic             is_repeat;
  } result_item_t;

  // state carried from scan to scan
  typedef struct packed {
    logic [WORD_W-1:0] last_group0;
    logic [WORD_W-1:0] last_group1;
    logic [KEY_W-1:0]  held_key;
    logic [WORD_W-1:0] last_report_tick;
    logic              repeating;
  } hold_state_t;

  // delay settings
  typedef struct packed {
    logic [CFG_W-1:0] first_delay_ms;
    logic [CFG_W-1:0] repeat_interval_ms;
  } delay_cfg_t;

endpackage

// ----- rtl/kca_scan_if.sv -----
// scan item channel: valid, ready and scan fields
interface kca_scan_if;
  import kca_pkg::*;

  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] scan_group0;
  logic [WORD_W-1:0] scan_group1;
  logic [WORD_W-1:0] tick_now;
  logic              clear_hold;

  modport source (output valid, output scan_group0, output scan_group1,
                  output tick_now, output clear_hold, input ready);
  modport sink   (input valid, input scan_group0, input scan_group1,
                  input tick_now, input clear_hold, output ready);
endinterface

// ----- rtl/kca_result_if.sv -----
// result item channel: valid, ready and report fields
interface kca_result_if;
  import kca_pkg::*;

  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] key_index;
  logic             is_repeat;

  modport source (output valid, output key_index, output is_repeat, input ready);
  modport sink   (input valid, input key_index, input is_repeat, output ready);
endinterface

// ----- rtl/kca_eval.sv -----
// click search, hold check and repeat timing for one scan
module kca_eval (
  input  kca_pkg::scan_item_t   item,
  input  kca_pkg::hold_state_t  state,
  input  kca_pkg::delay_cfg_t   cfg,
  output kca_pkg::result_item_t res,
  output kca_pkg::hold_state_t  state_next
);
  import kca_pkg::*;

  logic [KEY_W-1:0]  held_eff;
  logic [ENTRIES-1:0] click_hit;
  logic [KEY_W-1:0]  clicked;
  logic              held_ok;
  logic [KEY_W-1:0]  held_pos;
  logic [IDX_W-1:0]  held_idx;
  logic [WORD_W-1:0] held_now;
  logic              held_pressed;
  logic [WORD_W-1:0] diff;
  logic [CFG_W-1:0]  lim;
  logic              due;

  // clear flag drops the hold before anything else
  assign held_eff = item.clear_hold ? '0 : state.held_key;

  // per-key click detect: some mask bit high before, all low now
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      click_hit[i] =
        (((KEY_GRP[i] ? state.last_group1 : state.last_group0) & KEY_MASK[i]) != '0) &&
        (((KEY_GRP[i] ? item.scan_group1 : item.scan_group0) & KEY_MASK[i]) == '0);
    end
  end

  // lowest table position wins
  always_comb begin
    clicked = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (click_hit[i]) begin
        clicked = KEY_W'(i + 1);
      end
    end
  end

  // held key lookup
  assign held_ok      = (held_eff != '0) && (held_eff <= KEY_W'(ENTRIES));
  assign held_pos     = held_eff - KEY_W'(1);
  assign held_idx     = held_pos[IDX_W-1:0];
  assign held_now     = KEY_GRP[held_idx] ? item.scan_group1 : item.scan_group0;
  assign held_pressed = (held_now & KEY_MASK[held_idx]) == '0;

  // wrapping tick difference, negative never repeats
  assign diff = item.tick_now - state.last_report_tick;
  assign lim  = state.repeating ? cfg.repeat_interval_ms : cfg.first_delay_ms;
  assign due  = !diff[WORD_W-1] && (diff > {{(WORD_W-CFG_W){1'b0}}, lim});

  // report and next state
  always_comb begin
    res                         = '0;
    state_next                  = state;
    state_next.last_group0      = item.scan_group0;
    state_next.last_group1      = item.scan_group1;
    state_next.held_key         = held_eff;
    if (clicked != '0) begin
      state_next.held_key         = clicked;
      state_next.repeating        = 1'b0;
      state_next.last_report_tick = item.tick_now;
      res.key_index               = clicked;
    end else if (held_ok) begin
      if (held_pressed) begin
        if (due) begin
          state_next.repeating        = 1'b1;
          state_next.last_report_tick = item.tick_now;
          res.key_index               = held_eff;
          res.is_repeat               = 1'b1;
        end
      end else begin
        state_next.held_key = '0;
      end
    end else begin
      state_next.held_key = '0;
    end
  end

endmodule

// ----- rtl/key_click_autorepeat.sv -----
// top level: keypad click detector with autorepeat
//
// scan carries one keyboard scan per item (two active-low button words, a
// millisecond tick and a clear flag); result carries one report per scan:
// key_index 0 for nothing, else table position plus one, and is_repeat.
// Both channels move an item at a clock edge where valid and ready are high.
// An accepted scan lands in an input register; it is evaluated against the
// held-key state, and its report moves to the output register once that
// register is empty or its report is being taken. One scan per cycle is
// sustained while result.ready stays high: the state update is a single pass
// of table compares and one 32-bit subtract and compare between the two
// registers. When the receiver stalls, the report waits in the output
// register, the next scan waits in the input register, and scan.ready drops
// once both are full. cfg_we/cfg_index/cfg_data write the two delays;
// the user must make writes only while no scan is in flight; the block
// itself does not enforce this. rst (synchronous) empties both registers,
// forgets the held key, marks all buttons released and restores the delays
// to 500 and 175 ticks.
module key_click_autorepeat (
  input  logic                             clk,
  input  logic                             rst,
  kca_scan_if.sink                         scan,
  kca_result_if.source                     result,
  input  logic                             cfg_we,
  input  logic [kca_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [kca_pkg::CFG_W-1:0]        cfg_data
);
  import kca_pkg::*;

  logic         in_valid;
  scan_item_t   in_item;
  logic         out_valid;
  result_item_t out_res;
  hold_state_t  state;
  delay_cfg_t   cfg;
  result_item_t res_next;
  hold_state_t  state_next;
  logic         advance;

  // handshakes
  assign advance      = in_valid && (!out_valid || result.ready);
  assign scan.ready   = !in_valid || advance;
  assign result.valid     = out_valid;
  assign result.key_index = out_res.key_index;
  assign result.is_repeat = out_res.is_repeat;

  // evaluation of the registered scan
  kca_eval u_eval (
    .item       (in_item),
    .state      (state),
    .cfg        (cfg),
    .res        (res_next),
    .state_next (state_next)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (scan.ready) begin
      in_valid <= scan.valid;
    end
    if (scan.valid && scan.ready) begin
      in_item.scan_group0 <= scan.scan_group0;
      in_item.scan_group1 <= scan.scan_group1;
      in_item.tick_now    <= scan.tick_now;
      in_item.clear_hold  <= scan.clear_hold;
    end
  end

  // output register and hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid              <= 1'b0;
      state.last_group0      <= '1;
      state.last_group1      <= '1;
      state.held_key         <= '0;
      state.last_report_tick <= '0;
      state.repeating        <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
      state     <= state_next;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      out_res <= res_next;
    end
  end

  // delay registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.first_delay_ms     <= FIRST_DELAY_RESET;
      cfg.repeat_interval_ms <= REPEAT_INTERVAL_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FIRST_DELAY:     cfg.first_delay_ms     <= cfg_data;
        REG_REPEAT_INTERVAL: cfg.repeat_interval_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // a repeat always names a key
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.is_repeat |-> out_res.key_index != '0)
    else $error("repeat report without a key");

  // a fresh click becomes the held key and restarts the first delay
  assert property (@(posedge clk) disable iff (rst)
    advance && res_next.key_index != '0 && !res_next.is_repeat |=>
      state.held_key == out_res.key_index && !state.repeating)
    else $error("click did not take the hold");

  // a repeat keeps the hold and switches to the repeat interval
  assert property (@(posedge clk) disable iff (rst)
    advance && res_next.is_repeat |=>
      state.held_key == out_res.key_index && state.repeating)
    else $error("repeat lost the hold");

  // nothing is offered right after reset
  assert property (@(posedge clk)
    rst |=> !out_valid && !in_valid)
    else $error("registers not empty after reset");

endmodule
